### hdl/tcbh_pkg.sv
// ============================================================================
// tcbh_pkg: shared types and codes of the two-choice bin hashing store
// Command, status and register codes, the configuration bundle and the job
// record that travels from the front end through the queue to the back end.
// ============================================================================
package tcbh_pkg;

    // Default geometry of the store.
    localparam int N_BINS_DEF    = 1024;
    localparam int BIN_DEPTH_DEF = 16;

    // Depth of the queue between front end and back end (a power of two).
    localparam int QUEUE_DEPTH = 2;

    // Fixed field widths.
    localparam int HASH_W  = 10;
    localparam int ROW_IN_W = 4;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 4;

    // Commands.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVER_CAP = 2'd1;
    localparam logic [1:0] ST_BIN_FULL = 2'd2;
    localparam logic [1:0] ST_ROW_CAP  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DUPLICATE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROW      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_CAP = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUMMY     = 4'd3;

    // Configuration register reset values.
    localparam logic              DUPLICATE_RST = 1'b0;
    localparam logic              GROW_RST      = 1'b1;
    localparam logic [CNT_W-1:0]  START_CAP_RST = 5'd0;
    localparam logic [DATA_W-1:0] DUMMY_RST     = 64'd0;

    typedef struct packed {
        logic                     duplicate;
        logic                     grow;
        logic [CNT_W-1:0]         start_cap;
        logic signed [DATA_W-1:0] dummy;
    } t_cfg;

    // One command after its bin indexes have been reduced to the table size.
    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] element;
        logic [HASH_W-1:0]        bin0;
        logic [HASH_W-1:0]        bin1;
        logic                     read_table;
        logic [HASH_W-1:0]        read_bin;
        logic [ROW_IN_W-1:0]      read_row;
    } t_job;

endpackage

### hdl/tcbh_front.sv
// ============================================================================
// tcbh_front: command intake
// Registers each incoming command, reduces its bin indexes modulo the number
// of bins and hands the job to the queue.
// ============================================================================
module tcbh_front #(
    parameter int N_BINS = tcbh_pkg::N_BINS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_command,
    input  logic signed [tcbh_pkg::DATA_W-1:0] i_element,
    input  logic [tcbh_pkg::HASH_W-1:0]        i_hash_index0,
    input  logic [tcbh_pkg::HASH_W-1:0]        i_hash_index1,
    input  logic                               i_read_table,
    input  logic [tcbh_pkg::HASH_W-1:0]        i_read_bin,
    input  logic [tcbh_pkg::ROW_IN_W-1:0]      i_read_row,
    input  logic                               i_hold,
    input  logic                               i_q_ready,
    output logic                               o_q_push,
    output tcbh_pkg::t_job                     o_q_job
);

    localparam int HW = tcbh_pkg::HASH_W;
    // Reduction is needed only when an index can reach the number of bins.
    localparam bit NEED_MOD    = N_BINS < (1 << HW);
    localparam int RECIP_SHIFT = 2 * HW;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + N_BINS - 1) / N_BINS;
    localparam int PROD_W      = 3 * HW;

    logic           r_f_valid;
    tcbh_pkg::t_job r_f_job;
    logic [HW-1:0]  r_q0, r_q1, r_qr;

    logic [PROD_W-1:0] w_p0, w_p1, w_pr;
    logic              w_accept;

    // Quotient estimate by reciprocal; exact for ten-bit indexes.
    assign w_p0 = PROD_W'(i_hash_index0) * PROD_W'(RECIP);
    assign w_p1 = PROD_W'(i_hash_index1) * PROD_W'(RECIP);
    assign w_pr = PROD_W'(i_read_bin) * PROD_W'(RECIP);

    function automatic logic [HW-1:0] reduce(input logic [HW-1:0] x, input logic [HW-1:0] q);
        logic [2*HW-1:0] qn;
        logic [2*HW-1:0] r;
        qn = (2*HW)'(q) * (2*HW)'(N_BINS);
        r  = (2*HW)'(x) - qn;
        return NEED_MOD ? r[HW-1:0] : x;
    endfunction

    assign o_in_ready = !i_hold && (!r_f_valid || i_q_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_q_push   = r_f_valid && i_q_ready;

    always_comb begin
        o_q_job          = r_f_job;
        o_q_job.bin0     = reduce(r_f_job.bin0, r_q0);
        o_q_job.bin1     = reduce(r_f_job.bin1, r_q1);
        o_q_job.read_bin = reduce(r_f_job.read_bin, r_qr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_accept) begin
            r_f_valid <= 1'b1;
        end else if (o_q_push) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f_job.command    <= i_command;
            r_f_job.element    <= i_element;
            r_f_job.bin0       <= i_hash_index0;
            r_f_job.bin1       <= i_hash_index1;
            r_f_job.read_table <= i_read_table;
            r_f_job.read_bin   <= i_read_bin;
            r_f_job.read_row   <= i_read_row;
            r_q0               <= w_p0[RECIP_SHIFT +: HW];
            r_q1               <= w_p1[RECIP_SHIFT +: HW];
            r_qr               <= w_pr[RECIP_SHIFT +: HW];
        end
    end

endmodule

### hdl/tcbh_fifo.sv
// ============================================================================
// tcbh_fifo: job queue
// Small first-in first-out buffer of jobs between front end and back end.
// ============================================================================
module tcbh_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcbh_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output tcbh_pkg::t_job o_job
);

    localparam int DEPTH = tcbh_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tcbh_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_wr, w_rd;

    assign o_ready = r_count != (PTR_W + 1)'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    // Pointers wrap naturally because the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### hdl/tcbh_back.sv
// ============================================================================
// tcbh_back: bin store and command sequencer
// Holds the fill counters and element stores of both tables, executes one
// job at a time and drives the result register.
// ============================================================================
module tcbh_back #(
    parameter int N_BINS    = tcbh_pkg::N_BINS_DEF,
    parameter int BIN_DEPTH = tcbh_pkg::BIN_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tcbh_pkg::t_cfg                     i_cfg,
    input  logic                               i_q_valid,
    input  tcbh_pkg::t_job                     i_q_job,
    output logic                               o_q_pop,
    output logic                               o_init,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [tcbh_pkg::DATA_W-1:0] o_data_out,
    output logic                               o_chosen_table,
    output logic [tcbh_pkg::HASH_W-1:0]        o_chosen_bin,
    output logic [tcbh_pkg::CNT_W-1:0]         o_fill_count,
    output logic [tcbh_pkg::CNT_W-1:0]         o_capacity,
    output logic [1:0]                         o_status
);

    localparam int DW     = tcbh_pkg::DATA_W;
    localparam int HW     = tcbh_pkg::HASH_W;
    localparam int CW     = tcbh_pkg::CNT_W;
    localparam int BIN_W  = $clog2(N_BINS);
    localparam int FILL_W = $clog2(BIN_DEPTH + 1);
    localparam int CAP_W  = (FILL_W > CW) ? FILL_W : CW;
    localparam int SLOTS  = N_BINS * BIN_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    // Memories.
    logic [FILL_W-1:0] r_fill0  [N_BINS];
    logic [FILL_W-1:0] r_fill1  [N_BINS];
    logic [DW-1:0]     r_store0 [SLOTS];
    logic [DW-1:0]     r_store1 [SLOTS];
    logic [FILL_W-1:0] r_f0_rd, r_f1_rd;
    logic [DW-1:0]     r_s0_rd, r_s1_rd;

    // Control.
    logic [1:0]       r_state, n_state;
    logic [BIN_W-1:0] r_clr_idx;
    logic             r_clr_report, r_init;
    logic [CAP_W-1:0] r_cap, n_cap;
    tcbh_pkg::t_job   r_job;

    // Result register.
    logic             r_o_valid;
    logic [DW-1:0]    r_o_data;
    logic             r_o_table;
    logic [HW-1:0]    r_o_bin;
    logic [CW-1:0]    r_o_fill;
    logic [CW-1:0]    r_o_cap;
    logic [1:0]       r_o_status;

    logic             w_out_free, w_result;
    logic [DW-1:0]    w_data;
    logic             w_table;
    logic [HW-1:0]    w_bin;
    logic [FILL_W-1:0] w_fill;
    logic [1:0]       w_status;

    logic [BIN_W-1:0]  w_f0_ra, w_f1_ra, w_f0_wa, w_f1_wa;
    logic [FILL_W-1:0] w_f0_wd, w_f1_wd;
    logic              w_f0_we, w_f1_we, w_s0_we, w_s1_we;
    logic [ADDR_W-1:0] w_s_ra, w_s0_wa, w_s1_wa;
    logic              w_last;

    // Insert evaluation.
    logic              w_do0, w_do1, w_full0, w_full1, w_tab, w_over0, w_over1;
    logic [FILL_W-1:0] w_fn0, w_fn1, w_fa0, w_fa1;
    logic [CAP_W-1:0]  w_cap_a, w_cap_b;
    logic [FILL_W-1:0] w_rd_fill;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [HW-1:0] bin,
                                                     input logic [ADDR_W-1:0] row);
        return ADDR_W'(BIN_W'(bin)) * ADDR_W'(BIN_DEPTH) + row;
    endfunction

    assign w_out_free = !r_o_valid || i_out_ready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_init     = r_init;
    assign w_last     = r_clr_idx == BIN_W'(N_BINS - 1);

    // Read ports are addressed from the queue head when a job is taken.
    assign w_f0_ra = (i_q_job.command == tcbh_pkg::CMD_INSERT) ?
                     BIN_W'(i_q_job.bin0) : BIN_W'(i_q_job.read_bin);
    assign w_f1_ra = (i_q_job.command == tcbh_pkg::CMD_INSERT) ?
                     BIN_W'(i_q_job.bin1) : BIN_W'(i_q_job.read_bin);
    assign w_s_ra  = slot_addr(i_q_job.read_bin, ADDR_W'(i_q_job.read_row));

    // Insert: the two-choice pick compares fills; duplicate mode appends to both,
    // table 0 first, so the second append sees the capacity left by the first.
    always_comb begin
        w_tab   = r_f0_rd > r_f1_rd;
        w_do0   = i_cfg.duplicate || !w_tab;
        w_do1   = i_cfg.duplicate || w_tab;
        w_full0 = r_f0_rd >= FILL_W'(BIN_DEPTH);
        w_full1 = r_f1_rd >= FILL_W'(BIN_DEPTH);
        w_fn0   = r_f0_rd + 1'b1;
        w_fn1   = r_f1_rd + 1'b1;
        w_fa0   = w_full0 ? r_f0_rd : w_fn0;
        w_fa1   = w_full1 ? r_f1_rd : w_fn1;
        w_over0 = w_do0 && !w_full0 && !i_cfg.grow && (CAP_W'(w_fn0) > r_cap);
        w_cap_a = (w_do0 && !w_full0 && i_cfg.grow && (CAP_W'(w_fn0) > r_cap)) ?
                  CAP_W'(w_fn0) : r_cap;
        w_over1 = w_do1 && !w_full1 && !i_cfg.grow && (CAP_W'(w_fn1) > w_cap_a);
        w_cap_b = (w_do1 && !w_full1 && i_cfg.grow && (CAP_W'(w_fn1) > w_cap_a)) ?
                  CAP_W'(w_fn1) : w_cap_a;
        w_rd_fill = r_job.read_table ? r_f1_rd : r_f0_rd;
    end

    always_comb begin
        n_state  = r_state;
        n_cap    = r_cap;
        w_result = 1'b0;
        w_data   = '0;
        w_table  = 1'b0;
        w_bin    = '0;
        w_fill   = '0;
        w_status = tcbh_pkg::ST_OK;
        w_f0_we  = 1'b0;
        w_f1_we  = 1'b0;
        w_s0_we  = 1'b0;
        w_s1_we  = 1'b0;
        w_f0_wa  = BIN_W'(r_job.bin0);
        w_f1_wa  = BIN_W'(r_job.bin1);
        w_f0_wd  = w_fn0;
        w_f1_wd  = w_fn1;
        w_s0_wa  = slot_addr(r_job.bin0, ADDR_W'(r_f0_rd));
        w_s1_wa  = slot_addr(r_job.bin1, ADDR_W'(r_f1_rd));
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_job.command == tcbh_pkg::CMD_CLEAR) ? S_CLEAR : S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    w_result = 1'b1;
                    n_state  = S_IDLE;
                    case (r_job.command)
                        tcbh_pkg::CMD_INSERT: begin
                            w_data  = r_job.element;
                            w_table = !i_cfg.duplicate && w_tab;
                            w_bin   = w_table ? r_job.bin1 : r_job.bin0;
                            w_fill  = w_table ? w_fa1 : w_fa0;
                            if ((w_do0 && w_full0) || (w_do1 && w_full1)) begin
                                w_status = tcbh_pkg::ST_BIN_FULL;
                            end else if (w_over0 || w_over1) begin
                                w_status = tcbh_pkg::ST_OVER_CAP;
                            end
                            w_f0_we = w_do0 && !w_full0;
                            w_s0_we = w_do0 && !w_full0;
                            w_f1_we = w_do1 && !w_full1;
                            w_s1_we = w_do1 && !w_full1;
                            n_cap   = w_cap_b;
                        end
                        tcbh_pkg::CMD_READ: begin
                            w_table = r_job.read_table;
                            w_bin   = r_job.read_bin;
                            w_fill  = w_rd_fill;
                            if (CAP_W'(r_job.read_row) < CAP_W'(w_rd_fill)) begin
                                w_data = r_job.read_table ? r_s1_rd : r_s0_rd;
                            end else begin
                                w_data = i_cfg.dummy;
                            end
                            if (CAP_W'(r_job.read_row) >= r_cap) begin
                                w_status = tcbh_pkg::ST_ROW_CAP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                w_f0_we = 1'b1;
                w_f1_we = 1'b1;
                w_f0_wa = r_clr_idx;
                w_f1_wa = r_clr_idx;
                w_f0_wd = '0;
                w_f1_wd = '0;
                if (w_last) begin
                    if (!r_clr_report) begin
                        n_state = S_IDLE;
                    end else if (w_out_free) begin
                        w_result = 1'b1;
                        n_cap    = CAP_W'(i_cfg.start_cap);
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_clr_report <= 1'b0;
            r_init       <= 1'b1;
            r_cap        <= CAP_W'(tcbh_pkg::START_CAP_RST);
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap   <= n_cap;
            if (o_q_pop) begin
                r_clr_idx    <= '0;
                r_clr_report <= 1'b1;
            end else if (r_state == S_CLEAR && !w_last) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == S_CLEAR && w_last) begin
                r_init <= 1'b0;
            end
            if (w_result) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (w_result) begin
            r_o_data   <= w_data;
            r_o_table  <= w_table;
            r_o_bin    <= w_bin;
            r_o_fill   <= CW'(w_fill);
            r_o_cap    <= CW'(n_cap);
            r_o_status <= w_status;
        end
    end

    // Fill counter memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_f0_we) begin
            r_fill0[w_f0_wa] <= w_f0_wd;
        end
        if (o_q_pop) begin
            r_f0_rd <= r_fill0[w_f0_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f1_we) begin
            r_fill1[w_f1_wa] <= w_f1_wd;
        end
        if (o_q_pop) begin
            r_f1_rd <= r_fill1[w_f1_ra];
        end
    end

    // Element store memories.
    always_ff @(posedge i_clk) begin
        if (w_s0_we) begin
            r_store0[w_s0_wa] <= r_job.element;
        end
        if (o_q_pop) begin
            r_s0_rd <= r_store0[w_s_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_we) begin
            r_store1[w_s1_wa] <= r_job.element;
        end
        if (o_q_pop) begin
            r_s1_rd <= r_store1[w_s_ra];
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_data_out     = r_o_data;
    assign o_chosen_table = r_o_table;
    assign o_chosen_bin   = r_o_bin;
    assign o_fill_count   = r_o_fill;
    assign o_capacity     = r_o_cap;
    assign o_status       = r_o_status;

endmodule

### hdl/two_choice_bin_hashing.sv
// ============================================================================
// two_choice_bin_hashing: two-table binning store for two-choice hashing
// Configuration registers, command intake, job queue and bin store.
// ============================================================================
// The block keeps two tables of N_BINS bins, each bin holding up to BIN_DEPTH
// 64-bit elements. Hashing is done outside: every command transfer carries the
// candidate bin of table 0 and of table 1, and all bin indexes are reduced
// modulo N_BINS. An insert appends the element to the less full candidate bin
// (table 0 on a tie), or to both bins in duplicate mode; a read returns one
// slot of a bin, or the dummy value beyond the bin's fill; a clear empties all
// bins and reloads the running capacity from the start capacity. Every command
// produces exactly one result transfer. The back end handles one command at a
// time: for an insert, a read or an unused command the fill counters are read
// from memory as the job is taken in the idle state, and the result is made in
// the execute state, where an insert also writes the fill counter and element
// store; that state waits while the result register is still full. A clear
// zeroes one bin of each fill counter memory per cycle. After reset the same
// clearing pass runs, during which no command transfer is taken; configuration
// writes are taken at all times. The front end registers and index-reduces a
// command and places it in a two-entry queue, so commands keep flowing in while
// the back end works or while a finished result waits to be taken, until the
// queue fills. Configuration must only be written while the block is idle.
// ============================================================================
module two_choice_bin_hashing #(
    parameter int N_BINS    = tcbh_pkg::N_BINS_DEF,
    parameter int BIN_DEPTH = tcbh_pkg::BIN_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tcbh_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tcbh_pkg::DATA_W-1:0]           i_cfg_data,
    // Command channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_command,
    input  logic signed [tcbh_pkg::DATA_W-1:0]    i_element,
    input  logic [tcbh_pkg::HASH_W-1:0]           i_hash_index0,
    input  logic [tcbh_pkg::HASH_W-1:0]           i_hash_index1,
    input  logic                                  i_read_table,
    input  logic [tcbh_pkg::HASH_W-1:0]           i_read_bin,
    input  logic [tcbh_pkg::ROW_IN_W-1:0]         i_read_row,
    // Result channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [tcbh_pkg::DATA_W-1:0]    o_data_out,
    output logic                                  o_chosen_table,
    output logic [tcbh_pkg::HASH_W-1:0]           o_chosen_bin,
    output logic [tcbh_pkg::CNT_W-1:0]            o_fill_count,
    output logic [tcbh_pkg::CNT_W-1:0]            o_capacity,
    output logic [1:0]                            o_status
);

    // Configuration registers. Writes are always taken; an index beyond the
    // register list is accepted and ignored.
    tcbh_pkg::t_cfg r_cfg;

    // Front end to queue, queue to back end.
    logic           w_q_push, w_q_ready, w_q_valid, w_q_pop, w_init;
    tcbh_pkg::t_job w_push_job, w_head_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duplicate <= tcbh_pkg::DUPLICATE_RST;
            r_cfg.grow      <= tcbh_pkg::GROW_RST;
            r_cfg.start_cap <= tcbh_pkg::START_CAP_RST;
            r_cfg.dummy     <= tcbh_pkg::DUMMY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tcbh_pkg::REG_DUPLICATE: r_cfg.duplicate <= i_cfg_data[0];
                tcbh_pkg::REG_GROW:      r_cfg.grow      <= i_cfg_data[0];
                tcbh_pkg::REG_START_CAP: r_cfg.start_cap <= i_cfg_data[tcbh_pkg::CNT_W-1:0];
                tcbh_pkg::REG_DUMMY:     r_cfg.dummy     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Command intake: registers the command and reduces its bin indexes.
    // It holds off new transfers while the post-reset clearing pass runs.
    tcbh_front #(
        .N_BINS (N_BINS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_element     (i_element),
        .i_hash_index0 (i_hash_index0),
        .i_hash_index1 (i_hash_index1),
        .i_read_table  (i_read_table),
        .i_read_bin    (i_read_bin),
        .i_read_row    (i_read_row),
        .i_hold        (w_init),
        .i_q_ready     (w_q_ready),
        .o_q_push      (w_q_push),
        .o_q_job       (w_push_job)
    );

    // Job queue decoupling intake from execution.
    tcbh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_push_job),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_job   (w_head_job)
    );

    // Bin store and sequencer; it owns the result register that parts the
    // result channel from the rest of the block.
    tcbh_back #(
        .N_BINS    (N_BINS),
        .BIN_DEPTH (BIN_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (w_q_valid),
        .i_q_job        (w_head_job),
        .o_q_pop        (w_q_pop),
        .o_init         (w_init),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_out     (o_data_out),
        .o_chosen_table (o_chosen_table),
        .o_chosen_bin   (o_chosen_bin),
        .o_fill_count   (o_fill_count),
        .o_capacity     (o_capacity),
        .o_status       (o_status)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the two-choice bin hashing store
// Drives command transfers through a queue-fed driver, predicts every result
// with a behavioral copy of both bin tables, and checks each result transfer
// field by field; both sides idle in random bursts but in the final phase.
// ============================================================================
module tb_top;

    localparam int          DATA_W       = tcbh_pkg::DATA_W;
    localparam int          HASH_W       = tcbh_pkg::HASH_W;
    localparam int          CNT_W        = tcbh_pkg::CNT_W;
    localparam int          ROW_IN_W     = tcbh_pkg::ROW_IN_W;
    localparam int          CFG_IDX_W    = tcbh_pkg::CFG_IDX_W;
    localparam int          CLK_PERIOD   = 10;
    localparam int          N_BINS       = tcbh_pkg::N_BINS_DEF;
    localparam int          BIN_DEPTH    = tcbh_pkg::BIN_DEPTH_DEF;
    localparam int          RAND_PHASES  = 8;
    localparam int          PHASE_ITEMS  = 235;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          MAX_REPORTS  = 100;
    // The command code that the block accepts but does nothing with.
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    // One expected or observed result transfer.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     tbl;
        logic [HASH_W-1:0]        bin_idx;
        logic [CNT_W-1:0]         fill;
        logic [CNT_W-1:0]         cap;
        logic [1:0]               status;
    } t_bin_result;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts at a known
    // value so nothing floats while reset is held.
    // ------------------------------------------------------------------------
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_valid    = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index    = '0;
    logic [DATA_W-1:0]        i_cfg_data     = '0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_command      = tcbh_pkg::CMD_INSERT;
    logic signed [DATA_W-1:0] i_element      = '0;
    logic [HASH_W-1:0]        i_hash_index0  = '0;
    logic [HASH_W-1:0]        i_hash_index1  = '0;
    logic                     i_read_table   = 1'b0;
    logic [HASH_W-1:0]        i_read_bin     = '0;
    logic [ROW_IN_W-1:0]      i_read_row     = '0;
    logic                     o_out_valid;
    logic                     i_out_ready    = 1'b0;
    logic signed [DATA_W-1:0] o_data_out;
    logic                     o_chosen_table;
    logic [HASH_W-1:0]        o_chosen_bin;
    logic [CNT_W-1:0]         o_fill_count;
    logic [CNT_W-1:0]         o_capacity;
    logic [1:0]               o_status;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    two_choice_bin_hashing dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_element      (i_element),
        .i_hash_index0  (i_hash_index0),
        .i_hash_index1  (i_hash_index1),
        .i_read_table   (i_read_table),
        .i_read_bin     (i_read_bin),
        .i_read_row     (i_read_row),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_out     (o_data_out),
        .o_chosen_table (o_chosen_table),
        .o_chosen_bin   (o_chosen_bin),
        .o_fill_count   (o_fill_count),
        .o_capacity     (o_capacity),
        .o_status       (o_status)
    );

    // ------------------------------------------------------------------------
    // Behavioral copy of the store: fill counters and slots of both tables,
    // the running capacity and the four configuration registers.
    // ------------------------------------------------------------------------
    int unsigned        fill_t0  [N_BINS];
    int unsigned        fill_t1  [N_BINS];
    logic [DATA_W-1:0]  slots_t0 [N_BINS * BIN_DEPTH];
    logic [DATA_W-1:0]  slots_t1 [N_BINS * BIN_DEPTH];
    int unsigned        run_cap;
    bit                 dup_mode;
    bit                 grow_mode;
    int unsigned        start_cap;
    logic [DATA_W-1:0]  dummy_word;

    tcbh_pkg::t_job     pending_jobs [$];
    t_bin_result        bin_results  [$];
    tcbh_pkg::t_job     cur_job;
    int                 send_gap     = 0;
    int                 hold_gap     = 0;
    bit                 idle_on      = 1'b1;
    int                 fail_count   = 0;
    int                 cycle_count  = 0;

    // Appends one element to a bin of one table and returns its status.
    // A full bin drops the element and leaves fill and capacity alone.
    function automatic logic [1:0] append_elem(input bit tbl, input int unsigned b,
                                               input logic [DATA_W-1:0] e,
                                               output int unsigned fill_after);
        int unsigned f;
        f = tbl ? fill_t1[b] : fill_t0[b];
        fill_after = f;
        if (f >= BIN_DEPTH) return tcbh_pkg::ST_BIN_FULL;
        if (tbl) begin
            slots_t1[b * BIN_DEPTH + f] = e;
            fill_t1[b] = f + 1;
        end else begin
            slots_t0[b * BIN_DEPTH + f] = e;
            fill_t0[b] = f + 1;
        end
        fill_after = f + 1;
        if (f + 1 > run_cap) begin
            if (grow_mode) run_cap = f + 1;
            else return tcbh_pkg::ST_OVER_CAP;
        end
        return tcbh_pkg::ST_OK;
    endfunction

    // Applies one command to the copy of the store and returns the result
    // transfer that the block has to produce for it.
    function automatic t_bin_result predict_bin_step(input tcbh_pkg::t_job j);
        t_bin_result r;
        int unsigned f0, f1;
        logic [1:0]  s0, s1;
        logic [DATA_W-1:0] slot;
        r = '0;
        case (j.command)
            tcbh_pkg::CMD_INSERT: begin
                r.value = j.element;
                if (dup_mode) begin
                    // Both appends happen on their own; a drop outranks a flag.
                    s0 = append_elem(1'b0, j.bin0, j.element, f0);
                    s1 = append_elem(1'b1, j.bin1, j.element, f1);
                    if (s0 == tcbh_pkg::ST_BIN_FULL || s1 == tcbh_pkg::ST_BIN_FULL)
                        r.status = tcbh_pkg::ST_BIN_FULL;
                    else if (s0 != tcbh_pkg::ST_OK || s1 != tcbh_pkg::ST_OK)
                        r.status = tcbh_pkg::ST_OVER_CAP;
                    else
                        r.status = tcbh_pkg::ST_OK;
                    r.tbl     = 1'b0;
                    r.bin_idx = j.bin0;
                    r.fill    = CNT_W'(f0);
                end else begin
                    // Less full candidate wins; a tie goes to table 0.
                    if (fill_t0[j.bin0] > fill_t1[j.bin1]) begin
                        r.tbl     = 1'b1;
                        r.bin_idx = j.bin1;
                    end else begin
                        r.tbl     = 1'b0;
                        r.bin_idx = j.bin0;
                    end
                    r.status = append_elem(r.tbl, r.bin_idx, j.element, f0);
                    r.fill   = CNT_W'(f0);
                end
            end
            tcbh_pkg::CMD_READ: begin
                r.tbl     = j.read_table;
                r.bin_idx = j.read_bin;
                f0   = j.read_table ? fill_t1[j.read_bin] : fill_t0[j.read_bin];
                slot = j.read_table ? slots_t1[j.read_bin * BIN_DEPTH + j.read_row]
                                    : slots_t0[j.read_bin * BIN_DEPTH + j.read_row];
                r.fill   = CNT_W'(f0);
                r.value  = (j.read_row < f0) ? slot : dummy_word;
                r.status = (j.read_row >= run_cap) ? tcbh_pkg::ST_ROW_CAP : tcbh_pkg::ST_OK;
            end
            tcbh_pkg::CMD_CLEAR: begin
                foreach (fill_t0[k]) fill_t0[k] = 0;
                foreach (fill_t1[k]) fill_t1[k] = 0;
                run_cap = start_cap;
            end
            default: ;
        endcase
        r.cap = CNT_W'(run_cap);
        return r;
    endfunction

    function automatic tcbh_pkg::t_job make_job(input logic [1:0] cmd,
                                                input logic [DATA_W-1:0] e,
                                                input int unsigned h0, h1, input bit rt,
                                                input int unsigned rb, rr);
        tcbh_pkg::t_job j;
        j.command    = cmd;
        j.element    = e;
        j.bin0       = HASH_W'(h0);
        j.bin1       = HASH_W'(h1);
        j.read_table = rt;
        j.read_bin   = HASH_W'(rb);
        j.read_row   = ROW_IN_W'(rr);
        return j;
    endfunction

    // Queues one command for the driver.
    function automatic void add_job(input tcbh_pkg::t_job j);
        pending_jobs.insert(pending_jobs.size(), j);
    endfunction

    task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, fname, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration writes. The model register changes at the edge where the
    // transfer completes, while the block is idle or in the post-reset clear.
    // ------------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tcbh_pkg::REG_DUPLICATE: dup_mode   = val[0];
            tcbh_pkg::REG_GROW:      grow_mode  = val[0];
            tcbh_pkg::REG_START_CAP: start_cap  = 32'(val[CNT_W-1:0]);
            tcbh_pkg::REG_DUMMY:     dummy_word = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input bit dup, input bit grow, input int unsigned sc,
                              input logic [DATA_W-1:0] dummy);
        cfg_write(tcbh_pkg::REG_DUPLICATE, DATA_W'(dup));
        cfg_write(tcbh_pkg::REG_GROW, DATA_W'(grow));
        cfg_write(tcbh_pkg::REG_START_CAP, DATA_W'(sc));
        cfg_write(tcbh_pkg::REG_DUMMY, dummy);
    endtask

    // Waits until every queued command has been sent and every result has
    // come back, then lets a clearing pass run out before anything else.
    task automatic wait_idle();
        while (pending_jobs.size() != 0 || i_in_valid || bin_results.size() != 0)
            @(posedge i_clk);
        repeat (N_BINS + 8) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Command driver. The prediction for a command is made at the edge of its
    // transfer, so it sees the store exactly as the block does. A new command
    // is only loaded once the previous one has been taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                bin_results.insert(bin_results.size(), predict_bin_step(cur_job));
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (idle_on && pending_jobs.size() != 0 &&
                             $urandom_range(0, 15) == 0) begin
                    // Idle burst, this cycle included; the rest of it is drawn into send_gap.
                    send_gap   <= $urandom_range(0, 18);
                    i_in_valid <= 1'b0;
                end else if (pending_jobs.size() != 0) begin
                    cur_job        = pending_jobs.pop_front();
                    i_command     <= cur_job.command;
                    i_element     <= cur_job.element;
                    i_hash_index0 <= cur_job.bin0;
                    i_hash_index1 <= cur_job.bin1;
                    i_read_table  <= cur_job.read_table;
                    i_read_bin    <= cur_job.read_bin;
                    i_read_row    <= cur_job.read_row;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each result transfer is matched against the oldest
    // prediction; ready drops in random stall bursts but in the final phase.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_bin_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_gap    <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (bin_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, data_out %0h",
                             $time, o_data_out);
                    fail_count++;
                end else begin
                    want = bin_results.pop_front();
                    check_field("data_out", want.value, o_data_out);
                    check_field("chosen_table", DATA_W'(want.tbl),
                                DATA_W'(o_chosen_table));
                    check_field("chosen_bin", DATA_W'(want.bin_idx),
                                DATA_W'(o_chosen_bin));
                    check_field("fill_count", DATA_W'(want.fill),
                                DATA_W'(o_fill_count));
                    check_field("capacity", DATA_W'(want.cap), DATA_W'(o_capacity));
                    check_field("status", DATA_W'(want.status), DATA_W'(o_status));
                end
            end
            if (hold_gap != 0) begin
                hold_gap    <= hold_gap - 1;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                hold_gap    <= $urandom_range(0, 18);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[two_choice_bin_hashing] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: a directed opening, then phases of random commands, each
    // phase under its own register settings.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned    base0, base1, mask, pick;
        tcbh_pkg::t_job j;

        foreach (fill_t0[k]) fill_t0[k] = 0;
        foreach (fill_t1[k]) fill_t1[k] = 0;
        dup_mode   = tcbh_pkg::DUPLICATE_RST;
        grow_mode  = tcbh_pkg::GROW_RST;
        start_cap  = 32'(tcbh_pkg::START_CAP_RST);
        dummy_word = tcbh_pkg::DUMMY_RST;
        run_cap    = 32'(tcbh_pkg::START_CAP_RST);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two-choice, growing capacity, most negative dummy. Covers the tie
        // rule, the move to table 1, reads below and past the fill, the
        // unused command and a clear with every field bit set.
        set_config(1'b0, 1'b1, 0, 64'h8000_0000_0000_0000);
        add_job(make_job(tcbh_pkg::CMD_READ,   '0, 0, 0, 0, 0, 0));
        add_job(make_job(tcbh_pkg::CMD_INSERT, 64'h7fff_ffff_ffff_ffff, 0, 1023, 0, 0, 0));
        add_job(make_job(tcbh_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 0, 1023, 0, 0, 0));
        add_job(make_job(tcbh_pkg::CMD_INSERT, '1, 0, 1023, 0, 0, 0));
        add_job(make_job(tcbh_pkg::CMD_READ,   '0, 0, 0, 0, 0, 1));
        add_job(make_job(tcbh_pkg::CMD_READ,   '0, 0, 0, 1, 1023, 0));
        add_job(make_job(tcbh_pkg::CMD_READ,   '0, 0, 0, 1, 1023, 15));
        add_job(make_job(CMD_UNUSED,           '1, 1023, 1023, 1, 1023, 15));
        add_job(make_job(tcbh_pkg::CMD_CLEAR,  '1, 1023, 1023, 1, 1023, 15));
        wait_idle();

        // Duplicate mode with a fixed capacity of two: fills above it are
        // flagged until both bins are full and the last element is dropped.
        set_config(1'b1, 1'b0, 2, 64'h7fff_ffff_ffff_ffff);
        add_job(make_job(tcbh_pkg::CMD_CLEAR, '0, 0, 0, 0, 0, 0));
        for (int k = 0; k <= BIN_DEPTH; k++)
            add_job(make_job(tcbh_pkg::CMD_INSERT, {$urandom, $urandom}, 7, 9, 0, 0, 0));
        add_job(make_job(tcbh_pkg::CMD_READ, '0, 0, 0, 1, 9, 15));
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            // Phases 0 and 1 pin the register extremes; the rest are random.
            case (p)
                0: set_config(1'b0, 1'b1, 16, 64'h7fff_ffff_ffff_ffff);
                1: set_config(1'b1, 1'b0, 0,  64'h8000_0000_0000_0000);
                2: set_config(1'b0, 1'b0, $urandom_range(1, 15), {$urandom, $urandom});
                default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    $urandom_range(0, 16), {$urandom, $urandom});
            endcase
            // The final phase runs flat out on both sides.
            idle_on = (p != RAND_PHASES - 1);

            // Most traffic lands on a handful of hot bins so that ties, full
            // bins and capacity overflows come up often.
            base0 = $urandom_range(0, N_BINS - 1);
            base1 = $urandom_range(0, N_BINS - 1);
            mask  = (1 << $urandom_range(0, 3)) - 1;
            add_job(make_job(tcbh_pkg::CMD_CLEAR, '0, 0, 0, 0, 0, 0));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                j.command    = tcbh_pkg::CMD_INSERT;
                j.element    = {$urandom, $urandom};
                j.bin0       = HASH_W'($urandom);
                j.bin1       = HASH_W'($urandom);
                j.read_table = 1'($urandom);
                j.read_bin   = HASH_W'($urandom);
                j.read_row   = ROW_IN_W'($urandom);
                if ($urandom_range(0, 99) < 85) begin
                    j.bin0     = HASH_W'(base0 ^ ($urandom & mask));
                    j.bin1     = HASH_W'(base1 ^ ($urandom & mask));
                    j.read_bin = HASH_W'((j.read_table ? base1 : base0) ^ ($urandom & mask));
                end
                pick = $urandom_range(0, 99);
                if (pick < 35)      j.command = tcbh_pkg::CMD_READ;
                else if (pick < 36) j.command = tcbh_pkg::CMD_CLEAR;
                else if (pick < 38) j.command = CMD_UNUSED;
                add_job(j);
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("[two_choice_bin_hashing] OK");
        else
            $display("[two_choice_bin_hashing] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/tcbh_pkg.sv
hdl/tcbh_front.sv
hdl/tcbh_fifo.sv
hdl/tcbh_back.sv
hdl/two_choice_bin_hashing.sv
tb/tb_top.sv
